// File: design/tnq_pkg.sv
// Shared constants, codes and types of the ticket notify queue.
package tnq_pkg;

	// Table and counter sizes.
	localparam int WAITERS     = 16;
	localparam int TICKET_BITS = 32;
	localparam int MAX_RESULTS = 16;

	// Field widths of the channels.
	localparam int MODE_W   = 2;
	localparam int THREAD_W = 8;
	localparam int STATUS_W = 4;
	localparam int KIND_W   = 3;
	localparam int TOUT_W   = 32;

	// Derived widths.
	localparam int IDX_W = (WAITERS > 1) ? $clog2(WAITERS) : 1;
	localparam int CNT_W = $clog2(WAITERS + 1);
	localparam int RES_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
	localparam int ENT_W = TICKET_BITS + THREAD_W;

	typedef logic [TICKET_BITS-1:0] ticket_t;
	typedef logic [THREAD_W-1:0]    thread_t;
	typedef logic [IDX_W-1:0]       idx_t;

	// Operation codes of an input item.
	typedef enum logic [MODE_W-1:0] {
		MODE_WAIT = 2'd0,
		MODE_ONE  = 2'd1,
		MODE_ALL  = 2'd2
	} mode_t;

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_PROCEED = 3'd0,
		KIND_BLOCKED = 3'd1,
		KIND_WAKE    = 3'd2,
		KIND_NONE    = 3'd3,
		KIND_FULL    = 3'd4
	} kind_t;

	// Request from the control to the slot scanner.
	typedef struct packed {
		logic    start;
		logic    wake_all;
		ticket_t key;
	} scan_ctrl_t;

	// Outcome of one scan over the slot table.
	typedef struct packed {
		logic    done;
		logic    found;
		idx_t    idx;
		ticket_t ticket;
		thread_t thread;
	} scan_res_t;

endpackage

// File: design/tnq_if.sv
// Handshake channel interfaces for the request and result sides.
interface tnq_req_if;
	logic                          valid;
	logic                          ready;
	logic [tnq_pkg::MODE_W-1:0]    mode;
	logic [tnq_pkg::THREAD_W-1:0]  fiber_id;
	logic [tnq_pkg::STATUS_W-1:0]  block_status;

	modport source(output valid, output mode, output fiber_id, output block_status,
		input ready);
	modport sink(input valid, input mode, input fiber_id, input block_status,
		output ready);
endinterface

interface tnq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tnq_pkg::KIND_W-1:0]    kind;
	logic [tnq_pkg::THREAD_W-1:0]  woken_id;
	logic [tnq_pkg::STATUS_W-1:0]  new_status;
	logic [tnq_pkg::TOUT_W-1:0]    ticket_out;
	logic                          last;

	modport source(output valid, output kind, output woken_id, output new_status,
		output ticket_out, output last, input ready);
	modport sink(input valid, input kind, input woken_id, input new_status,
		input ticket_out, input last, output ready);
endinterface

// File: design/ticket_notify_queue_core.sv
// Ticket notify queue: the counters, slot valid bits, control and result register.
// A wait, a notify on equal counters or a notify on an empty table loads its result in
// the decide step; the queue then returns to idle to take the next item.
// A notify that looks up a waiter scans in the scan state and loads its result in the emit
// state; a notify-all then gives each further wake by a rescan and a new emit state.
// Reset clears both counters and all slot valid bits at once; the slot RAM is not cleared.
module ticket_notify_queue_core (
	input  logic       clk,
	input  logic       arst_n,
	tnq_req_if.sink    req,
	tnq_rsp_if.source  rsp
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECIDE = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t                              state_q, state_d;
	tnq_pkg::mode_t                      mode_q;
	tnq_pkg::thread_t                    id_q;
	logic [tnq_pkg::STATUS_W-1:0]        status_q;
	tnq_pkg::ticket_t                    issued_q, issued_d;
	tnq_pkg::ticket_t                    served_q, served_d;
	tnq_pkg::ticket_t                    target_q, target_d;
	logic [tnq_pkg::WAITERS-1:0]         valid_q, valid_d;
	logic [tnq_pkg::RES_W-1:0]           nres_q, nres_d;

	logic                                ovalid_q;
	tnq_pkg::kind_t                      okind_q;
	tnq_pkg::thread_t                    oid_q;
	logic [tnq_pkg::STATUS_W-1:0]        ostat_q;
	tnq_pkg::ticket_t                    otkt_q;
	logic                                olast_q;

	logic                                out_free;
	logic                                res_load;
	tnq_pkg::kind_t                      res_kind;
	tnq_pkg::thread_t                    res_id;
	logic [tnq_pkg::STATUS_W-1:0]        res_stat;
	tnq_pkg::ticket_t                    res_tkt;
	logic                                res_last;

	logic                                free_any;
	tnq_pkg::idx_t                       free_idx;
	logic [tnq_pkg::WAITERS-1:0]         rem_valid;
	logic                                all_last;

	logic                                ram_we;
	logic                                ram_re;
	tnq_pkg::idx_t                       ram_raddr;
	logic [tnq_pkg::ENT_W-1:0]           ram_rdata;
	logic                                scan_start;
	tnq_pkg::scan_ctrl_t                 sctl;
	tnq_pkg::scan_res_t                  sres;

	// Slot table payload: ticket and thread id of each parked waiter.
	tnq_ram #(
		.WIDTH(tnq_pkg::ENT_W),
		.DEPTH(tnq_pkg::WAITERS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata ({issued_q, id_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tnq_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (sctl),
		.valid   (valid_q),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata),
		.res     (sres)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign out_free  = !ovalid_q || rsp.ready;

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = tnq_pkg::WAITERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = tnq_pkg::IDX_W'(i);
			end
		end
	end
	assign free_any = !(&valid_q);

	// Slots left after the chosen waiter is woken, and whether this wake ends the item.
	always_comb begin
		rem_valid           = valid_q;
		rem_valid[sres.idx] = 1'b0;
	end
	assign all_last = (rem_valid == '0) ||
		(nres_q == tnq_pkg::RES_W'(tnq_pkg::MAX_RESULTS - 1));

	// Scanner request: a fresh lookup from the decide step, a rescan from the emit step.
	always_comb begin
		sctl.start    = scan_start;
		sctl.wake_all = (mode_q == tnq_pkg::MODE_ALL);
		if (state_q == ST_DECIDE) begin
			sctl.key = sctl.wake_all ? issued_q : served_q;
		end else begin
			sctl.key = target_q;
		end
	end

	// Main control: counters, valid bits and the next result.
	always_comb begin
		state_d    = state_q;
		issued_d   = issued_q;
		served_d   = served_q;
		target_d   = target_q;
		valid_d    = valid_q;
		nres_d     = nres_q;
		ram_we     = 1'b0;
		scan_start = 1'b0;
		res_load   = 1'b0;
		res_kind   = tnq_pkg::KIND_NONE;
		res_id     = '0;
		res_stat   = '0;
		res_tkt    = '0;
		res_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (out_free) begin
					state_d = ST_IDLE;
					case (mode_q)
						tnq_pkg::MODE_WAIT: begin
							res_load = 1'b1;
							res_id   = id_q;
							res_tkt  = issued_q;
							if (issued_q < served_q) begin
								res_kind = tnq_pkg::KIND_PROCEED;
								issued_d = issued_q + tnq_pkg::TICKET_BITS'(1);
							end else if (free_any) begin
								res_kind          = tnq_pkg::KIND_BLOCKED;
								res_stat          = status_q;
								ram_we            = 1'b1;
								valid_d[free_idx] = 1'b1;
								issued_d          = issued_q + tnq_pkg::TICKET_BITS'(1);
							end else begin
								res_kind = tnq_pkg::KIND_FULL;
								res_stat = status_q;
							end
						end
						tnq_pkg::MODE_ONE: begin
							res_tkt = served_q;
							if (issued_q == served_q || valid_q == '0) begin
								res_load = 1'b1;
							end else begin
								scan_start = 1'b1;
								state_d    = ST_SCAN;
							end
							if (issued_q != served_q) begin
								served_d = served_q + tnq_pkg::TICKET_BITS'(1);
								target_d = served_q;
							end
						end
						tnq_pkg::MODE_ALL: begin
							res_tkt = served_q;
							nres_d  = '0;
							if (issued_q == served_q || valid_q == '0) begin
								res_load = 1'b1;
							end else begin
								scan_start = 1'b1;
								state_d    = ST_SCAN;
							end
							served_d = issued_q;
							target_d = issued_q;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (sres.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
					if (!sres.found) begin
						res_tkt = target_q;
					end else if (mode_q == tnq_pkg::MODE_ALL) begin
						res_kind = tnq_pkg::KIND_WAKE;
						res_id   = sres.thread;
						res_tkt  = sres.ticket;
						res_last = all_last;
						if (all_last) begin
							// Waiters beyond the result limit leave without a result.
							valid_d = '0;
						end else begin
							valid_d    = rem_valid;
							nres_d     = nres_q + tnq_pkg::RES_W'(1);
							scan_start = 1'b1;
							state_d    = ST_SCAN;
						end
					end else begin
						res_kind          = tnq_pkg::KIND_WAKE;
						res_id            = sres.thread;
						res_tkt           = sres.ticket;
						valid_d[sres.idx] = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= '0;
			served_q <= '0;
			valid_q  <= '0;
			nres_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issued_q <= issued_d;
			served_q <= served_d;
			valid_q  <= valid_d;
			nres_q   <= nres_d;
			if (res_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Item capture and result register payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q   <= tnq_pkg::mode_t'(req.mode);
			id_q     <= req.fiber_id;
			status_q <= req.block_status;
		end
		target_q <= target_d;
		if (res_load) begin
			okind_q <= res_kind;
			oid_q   <= res_id;
			ostat_q <= res_stat;
			otkt_q  <= res_tkt;
			olast_q <= res_last;
		end
	end

	assign rsp.valid      = ovalid_q;
	assign rsp.kind       = okind_q;
	assign rsp.woken_id   = oid_q;
	assign rsp.new_status = ostat_q;
	assign rsp.ticket_out = tnq_pkg::TOUT_W'(otkt_q);
	assign rsp.last       = olast_q;

	// A new result never overwrites one that has not been transferred.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!ovalid_q || rsp.ready))
		else $error("result register overwritten before transfer");

	// The slot RAM is read only during a scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (state_q == ST_SCAN))
		else $error("slot RAM read outside a scan");

	// A single notify wakes only the waiter that holds the released ticket.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && mode_q == tnq_pkg::MODE_ONE && sres.found) |->
		(sres.ticket == target_q))
		else $error("notify woke a waiter with the wrong ticket");

	// Slots are only taken by a wait item in its decide step.
	assert property (@(posedge clk) disable iff (!arst_n)
		((valid_q & ~$past(valid_q)) != '0) |->
		$past(state_q == ST_DECIDE && mode_q == tnq_pkg::MODE_WAIT))
		else $error("slot marked valid outside a wait");

endmodule

// File: design/tnq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tnq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/tnq_scan.sv
// Slot scanner: walks the slot RAM one entry a cycle and keeps the best match.
module tnq_scan (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tnq_pkg::scan_ctrl_t                ctrl,
	input  logic [tnq_pkg::WAITERS-1:0]        valid,
	output logic                               rd_en,
	output tnq_pkg::idx_t                      rd_addr,
	input  logic [tnq_pkg::ENT_W-1:0]          rd_data,
	output tnq_pkg::scan_res_t                 res
);

	logic                          busy_q;
	logic                          done_q;
	logic [tnq_pkg::CNT_W-1:0]     cnt_q;
	logic                          rd_s1;
	tnq_pkg::idx_t                 idx_s1;
	logic                          wake_all_q;
	tnq_pkg::ticket_t              key_q;
	logic                          found_q;
	tnq_pkg::idx_t                 best_idx_q;
	tnq_pkg::ticket_t              best_tkt_q;
	tnq_pkg::ticket_t              best_dist_q;
	tnq_pkg::thread_t              best_thr_q;

	tnq_pkg::ticket_t              ent_tkt;
	tnq_pkg::thread_t              ent_thr;
	tnq_pkg::ticket_t              ent_dist;
	logic                          issuing;
	logic                          hit;

	// Read address issue: one entry per cycle while the counter is below the depth.
	assign issuing = busy_q && (cnt_q < tnq_pkg::CNT_W'(tnq_pkg::WAITERS));
	assign rd_en   = issuing;
	assign rd_addr = cnt_q[tnq_pkg::IDX_W-1:0];

	// Evaluate the entry that the RAM returned in this cycle.
	assign ent_tkt  = rd_data[tnq_pkg::ENT_W-1 -: tnq_pkg::TICKET_BITS];
	assign ent_thr  = rd_data[tnq_pkg::THREAD_W-1:0];
	assign ent_dist = key_q - ent_tkt;

	always_comb begin
		hit = 1'b0;
		if (rd_s1 && valid[idx_s1]) begin
			if (wake_all_q) begin
				hit = !found_q || (ent_dist < best_dist_q);
			end else begin
				hit = !found_q && (ent_tkt == key_q);
			end
		end
	end

	// Scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			rd_s1   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				rd_s1   <= 1'b0;
				found_q <= 1'b0;
			end else if (busy_q) begin
				rd_s1 <= issuing;
				if (issuing) begin
					cnt_q <= cnt_q + tnq_pkg::CNT_W'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
				if (!issuing && !rd_s1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Scan payload: the key, the stage index and the best entry so far.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			wake_all_q <= ctrl.wake_all;
			key_q      <= ctrl.key;
		end
		idx_s1 <= cnt_q[tnq_pkg::IDX_W-1:0];
		if (hit) begin
			best_idx_q  <= idx_s1;
			best_tkt_q  <= ent_tkt;
			best_dist_q <= ent_dist;
			best_thr_q  <= ent_thr;
		end
	end

	assign res.done   = done_q;
	assign res.found  = found_q;
	assign res.idx    = best_idx_q;
	assign res.ticket = best_tkt_q;
	assign res.thread = best_thr_q;

endmodule

// File: test/tnq_checker.sv
// Checker for the ticket notify queue: tracks tickets and parked waiters and compares every result.
`timescale 1ns / 100ps
module tnq_checker
	import tnq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tnq_req_if   req,
	tnq_rsp_if   rsp,
	output int   mismatch_count,
	output int   outstanding
);

	// One result as the queue should report it.
	typedef struct {
		kind_t               kind;
		thread_t             woken_id;
		logic [STATUS_W-1:0] new_status;
		ticket_t             ticket;
		logic                last;
	} notice_t;

	// Ticket counters and the table of parked waiters.
	ticket_t            issued_q;
	ticket_t            served_q;
	logic [WAITERS-1:0] parked;
	ticket_t            park_ticket [WAITERS];
	thread_t            park_thread [WAITERS];

	notice_t due_notices [$];

	task automatic report(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic post(kind_t kind, thread_t id, logic [STATUS_W-1:0] status, ticket_t ticket,
		logic last);
		notice_t n;
		n.kind = kind;
		n.woken_id = id;
		n.new_status = status;
		n.ticket = ticket;
		n.last = last;
		due_notices.push_back(n);
	endtask

	// Apply one accepted request to the tracked state and queue its results.
	task automatic serve_request(mode_t op, thread_t id, logic [STATUS_W-1:0] status);
		int      i;
		int      slot;
		int      best;
		int      woken;
		ticket_t gap;
		ticket_t best_gap;
		ticket_t start;
		notice_t tail;
		slot = -1;
		best = -1;
		woken = 0;
		best_gap = '0;
		start = served_q;
		case (op)
		MODE_WAIT: begin
			if (issued_q < served_q) begin
				post(KIND_PROCEED, id, '0, issued_q, 1'b1);
				issued_q++;
			end else begin
				// The lowest free slot takes the waiter.
				for (i = WAITERS - 1; i >= 0; i--)
					if (!parked[i])
						slot = i;
				if (slot < 0) begin
					post(KIND_FULL, id, status, issued_q, 1'b1);
				end else begin
					parked[slot] = 1'b1;
					park_ticket[slot] = issued_q;
					park_thread[slot] = id;
					post(KIND_BLOCKED, id, status, issued_q, 1'b1);
					issued_q++;
				end
			end
		end
		MODE_ONE: begin
			if (issued_q == served_q) begin
				post(KIND_NONE, '0, '0, served_q, 1'b1);
			end else begin
				served_q++;
				for (i = WAITERS - 1; i >= 0; i--)
					if (parked[i] && park_ticket[i] == start)
						slot = i;
				if (slot < 0) begin
					post(KIND_NONE, '0, '0, start, 1'b1);
				end else begin
					parked[slot] = 1'b0;
					post(KIND_WAKE, park_thread[slot], '0, start, 1'b1);
				end
			end
		end
		MODE_ALL: begin
			if (issued_q != served_q) begin
				// Wake the newest waiter first, ties going to the lowest slot.
				do begin
					best = -1;
					for (i = 0; i < WAITERS; i++) begin
						if (parked[i]) begin
							gap = issued_q - park_ticket[i];
							if (best < 0 || gap < best_gap) begin
								best = i;
								best_gap = gap;
							end
						end
					end
					if (best >= 0) begin
						parked[best] = 1'b0;
						if (woken < MAX_RESULTS) begin
							post(KIND_WAKE, park_thread[best], '0, park_ticket[best], 1'b0);
							woken++;
						end
					end
				end while (best >= 0);
				served_q = issued_q;
			end
			if (woken == 0) begin
				post(KIND_NONE, '0, '0, start, 1'b1);
			end else begin
				tail = due_notices.pop_back();
				tail.last = 1'b1;
				due_notices.push_back(tail);
			end
		end
		default: ;
		endcase
	endtask

	// Requests are predicted before results are compared, so a result at the same edge
	// always belongs to an earlier request.
	always @(posedge clk or negedge arst_n) begin
		notice_t want;
		if (!arst_n) begin
			issued_q = '0;
			served_q = '0;
			parked = '0;
			due_notices.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (req.valid && req.ready)
				serve_request(mode_t'(req.mode), req.fiber_id, req.block_status);
			if (rsp.valid && rsp.ready) begin
				if (due_notices.size() == 0) begin
					report($sformatf("result with nothing expected: kind %0d id %0d ticket %0d",
						rsp.kind, rsp.woken_id, rsp.ticket_out));
				end else begin
					want = due_notices.pop_front();
					if (rsp.kind !== want.kind)
						report($sformatf("kind want %0d got %0d", want.kind, rsp.kind));
					if (rsp.woken_id !== want.woken_id)
						report($sformatf("woken_id want %0d got %0d", want.woken_id, rsp.woken_id));
					if (rsp.new_status !== want.new_status)
						report($sformatf("new_status want %0d got %0d", want.new_status,
							rsp.new_status));
					if (rsp.ticket_out !== want.ticket[TOUT_W-1:0])
						report($sformatf("ticket_out want %0d got %0d", want.ticket[TOUT_W-1:0],
							rsp.ticket_out));
					if (rsp.last !== want.last)
						report($sformatf("last want %0d got %0d", want.last, rsp.last));
				end
			end
			outstanding = due_notices.size();
		end
	end

endmodule

// File: test/testbench.sv
// Top of the ticket notify queue test: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 100ps
module testbench;
	import tnq_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int PHASE_ITEMS  = 60;
	localparam int CYCLE_LIMIT  = 3000000;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   outstanding;
	int   cycles;
	int   idle_pct;
	int   stall_pct;

	tnq_req_if req_ch ();
	tnq_rsp_if rsp_ch ();

	ticket_notify_queue_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tnq_checker i_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The receiver stalls at random with the current phase's rate.
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Hard stop in case the queue hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// One request transfer, preceded by random idle cycles; ready is sampled at the falling
	// edge, where it is stable until the next rising edge.
	task automatic send(mode_t op, thread_t id, logic [STATUS_W-1:0] status);
		logic took;
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= op;
		req_ch.fiber_id <= id;
		req_ch.block_status <= status;
		do begin
			@(negedge clk);
			took = req_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Stop sending until every expected result has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic set_phase(int p);
		case (p % 4)
		0: begin idle_pct = 0;  stall_pct = 0;  end
		1: begin idle_pct = 80; stall_pct = 0;  end
		2: begin idle_pct = 0;  stall_pct = 80; end
		default: begin idle_pct = 37; stall_pct = 37; end
		endcase
	endtask

	initial begin
		int i;
		int k;
		int burst;
		int sent;
		int phase;
		int next_phase;
		arst_n = 1'b0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_WAIT;
		req_ch.fiber_id = '0;
		req_ch.block_status = '0;
		rsp_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: notifies on an empty queue, field extremes, a full table, then a
		// notify-all over a nearly full table.
		send(MODE_ONE, 8'h00, 4'h0);
		send(MODE_ALL, 8'hFF, 4'hF);
		send(MODE_WAIT, 8'h00, 4'h0);
		send(MODE_WAIT, 8'hFF, 4'hF);
		send(MODE_ONE, 8'h00, 4'h0);
		send(MODE_ALL, 8'h00, 4'h0);
		for (i = 0; i < WAITERS; i++)
			send(MODE_WAIT, thread_t'(i * 17), 4'(i));
		send(MODE_WAIT, 8'hA5, 4'hA);
		send(MODE_ONE, 8'h5A, 4'h5);
		send(MODE_ALL, 8'h3C, 4'h3);

		// Let everything come back before the random part.
		drain();

		// Random: bursts of waits followed by notifies, some notify-alls and stray items,
		// which include the unused mode.
		sent = 0;
		phase = 0;
		next_phase = PHASE_ITEMS;
		set_phase(phase);
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 20);
			for (k = 0; k < burst; k++) begin
				send(MODE_WAIT, thread_t'($urandom_range(255)), 4'($urandom_range(15)));
				sent++;
			end
			burst = $urandom_range(0, burst + 2);
			for (k = 0; k < burst; k++) begin
				send(MODE_ONE, thread_t'($urandom_range(255)), 4'($urandom_range(15)));
				sent++;
			end
			if ($urandom_range(3) == 0) begin
				send(MODE_ALL, thread_t'($urandom_range(255)), 4'($urandom_range(15)));
				sent++;
			end
			if ($urandom_range(9) == 0) begin
				send(mode_t'($urandom_range(3)), thread_t'($urandom_range(255)),
					4'($urandom_range(15)));
				sent++;
			end
			if (sent >= next_phase) begin
				phase++;
				next_phase += PHASE_ITEMS;
				set_phase(phase);
			end
		end

		// Wait for the last results, then a few more cycles for anything stray.
		drain();
		repeat (40) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
